@@ design/ptsd_pkg.sv @@
`timescale 1ns / 1ps

package ptsd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_start;
        logic [2:0] skip_bits;
        logic       upper_only;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_string;
    } t_out_item;

    // characters decoded from one byte, one or two of them
    typedef struct packed {
        logic      two;
        t_out_item first;
        t_out_item second;
    } t_pair;

    // working buffer: at most five leftover bits plus one new byte
    localparam int WORK_W      = 13;
    localparam int WORK_CNT_W  = 4;
    localparam int STORE_W     = 5;
    localparam int STORE_CNT_W = 3;
    localparam int EXTRACT_MAX = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [3:0] SHORT_W  = 4'd5;
    localparam logic [3:0] LONG_W   = 4'd6;
    localparam logic [3:0] ESCAPE_W = 4'd4;

    localparam logic [5:0] CODE_LAST_UPPER  = 6'd25;
    localparam logic [5:0] CODE_DASH        = 6'd26;
    localparam logic [5:0] CODE_UNDERSCORE  = 6'd27;
    localparam logic [5:0] CODE_PERCENT     = 6'd28;
    localparam logic [5:0] CODE_SPACE       = 6'd29;
    localparam logic [5:0] CODE_SLASH       = 6'd30;
    localparam logic [5:0] CODE_TERM        = 6'd31;
    localparam logic [5:0] CODE_FIRST_LOWER = 6'd32;
    localparam logic [5:0] CODE_LAST_LOWER  = 6'd57;
    localparam logic [5:0] CODE_LPAREN      = 6'd58;
    localparam logic [5:0] CODE_RPAREN      = 6'd59;
    localparam logic [5:0] CODE_AMP         = 6'd60;
    localparam logic [5:0] CODE_PLUS        = 6'd61;
    localparam logic [5:0] CODE_COMMA       = 6'd62;
    localparam logic [5:0] CODE_ESC         = 6'd63;

    localparam logic [3:0] ESC_LAST_DIGIT = 4'd9;
    localparam logic [3:0] ESC_DOT        = 4'd10;
    localparam logic [3:0] ESC_APOS       = 4'd11;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UNKNOWN = 8'h3F;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    function automatic logic [7:0] map_code(input logic [5:0] x);
        logic [7:0] ch;
        ch = CHAR_UNKNOWN;
        if (x <= CODE_LAST_UPPER) begin
            ch = CHAR_UPPER_A + {2'b00, x};
        end else if (x >= CODE_FIRST_LOWER && x <= CODE_LAST_LOWER) begin
            ch = CHAR_LOWER_A + {2'b00, x - CODE_FIRST_LOWER};
        end else begin
            case (x)
                CODE_DASH:       ch = 8'h2D;
                CODE_UNDERSCORE: ch = 8'h5F;
                CODE_PERCENT:    ch = 8'h25;
                CODE_SPACE:      ch = 8'h20;
                CODE_SLASH:      ch = 8'h2F;
                CODE_TERM:       ch = CHAR_NUL;
                CODE_LPAREN:     ch = 8'h28;
                CODE_RPAREN:     ch = 8'h29;
                CODE_AMP:        ch = 8'h26;
                CODE_PLUS:       ch = 8'h2B;
                CODE_COMMA:      ch = 8'h2C;
                default:         ch = CHAR_UNKNOWN;
            endcase
        end
        return ch;
    endfunction

    function automatic logic [7:0] map_escape(input logic [3:0] x);
        logic [7:0] ch;
        ch = CHAR_UNKNOWN;
        if (x <= ESC_LAST_DIGIT) begin
            ch = CHAR_ZERO + {4'b0000, x};
        end else if (x == ESC_DOT) begin
            ch = 8'h2E;
        end else if (x == ESC_APOS) begin
            ch = 8'h27;
        end
        return ch;
    endfunction

endpackage

@@ design/packed_text_string_decoder_top.sv @@
`timescale 1ns / 1ps

// packed text string decoder
// input queue port: one stream byte per transfer (push while full is low), with
// string_start, skip_bits and upper_only qualifying the first byte of a string.
// result queue port: one ascii character per transfer (pop while empty is low);
// end_of_string marks the terminating nul, after which bytes are dropped until
// the next string_start.
// one byte is taken every cycle while the 4-entry queue of character pairs has
// room; the byte's one or two characters are worked out in the cycle it is
// transferred; characters go through the queue, then the output register.
// throughput: one byte per cycle in while full is low, one character per cycle
// out while pop is high; a byte that yields two characters holds the output
// register for two transfers.
// when pop stays low the queue fills and full rises after five bytes that
// produce characters (one waits in the output register, four in the queue);
// bytes without characters still need full low.
// reset clears the bit buffer, the string state, the queue count and pointers
// and the output valid flag; empty is high and full is low right after reset.
module packed_text_string_decoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  ptsd_pkg::t_in_item  i_item,
    input  logic                pop,
    output logic                empty,
    output ptsd_pkg::t_out_item o_result
);
    import ptsd_pkg::*;

    logic  accept;
    logic  emit;
    t_pair front_pair;
    t_pair q_pair;
    logic  q_empty;
    logic  q_full;
    logic  q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    ptsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_emit   (emit),
        .o_pair   (front_pair)
    );

    ptsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_pair  (front_pair),
        .i_pop   (q_pop),
        .o_pair  (q_pair),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ptsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_pair  (q_pair),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

@@ design/ptsd_front.sv @@
`timescale 1ns / 1ps

module ptsd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ptsd_pkg::t_in_item i_item,
    output logic               o_emit,
    output ptsd_pkg::t_pair    o_pair
);
    import ptsd_pkg::*;

    logic [STORE_W-1:0]     r_store, n_store;
    logic [STORE_CNT_W-1:0] r_held, n_held;
    logic                   r_esc, n_esc;
    logic                   r_short, n_short;
    logic                   r_active, n_active;

    always_comb begin
        logic [WORK_W-1:0]     v;
        logic [WORK_CNT_W-1:0] h;
        logic [WORK_CNT_W-1:0] w;
        logic [5:0]            x6;
        logic [3:0]            x4;
        logic                  esc;
        logic                  sc;
        logic                  active;
        logic                  done;
        logic                  emit_now;
        logic [1:0]            cnt;
        t_out_item             res;

        n_store  = r_store;
        n_held   = r_held;
        n_esc    = r_esc;
        n_short  = r_short;
        n_active = r_active;
        o_emit   = 1'b0;
        o_pair   = '0;

        v        = WORK_W'(r_store);
        h        = WORK_CNT_W'(r_held);
        esc      = r_esc;
        sc       = r_short;
        active   = r_active;
        done     = 1'b0;
        cnt      = 2'd0;
        w        = LONG_W;
        x6       = '0;
        x4       = '0;
        emit_now = 1'b0;
        res      = '0;

        if (i_accept && (i_item.string_start || r_active)) begin
            if (i_item.string_start) begin
                v      = WORK_W'(i_item.data_byte >> i_item.skip_bits);
                h      = WORK_CNT_W'(4'd8 - {1'b0, i_item.skip_bits});
                esc    = 1'b0;
                sc     = i_item.upper_only;
                active = 1'b1;
            end else begin
                v = WORK_W'(r_store) | (WORK_W'(i_item.data_byte) << r_held);
                h = WORK_CNT_W'(r_held) + WORK_CNT_W'(8);
            end

            // at most three extractions fit in the bits of one byte step
            for (int k = 0; k < EXTRACT_MAX; k++) begin
                emit_now = 1'b0;
                if (!done && active && cnt != 2'd2) begin
                    if (esc) begin
                        if (h < ESCAPE_W) begin
                            done = 1'b1;
                        end else begin
                            x4       = v[3:0];
                            v        = v >> ESCAPE_W;
                            h        = h - ESCAPE_W;
                            esc      = 1'b0;
                            res      = '{char_code: map_escape(x4), end_of_string: 1'b0};
                            emit_now = 1'b1;
                        end
                    end else begin
                        w = sc ? SHORT_W : LONG_W;
                        if (h < w) begin
                            done = 1'b1;
                        end else begin
                            x6 = sc ? {1'b0, v[4:0]} : v[5:0];
                            v  = v >> w;
                            h  = h - w;
                            if (x6 == CODE_ESC) begin
                                esc = 1'b1;
                            end else begin
                                res      = '{char_code: map_code(x6),
                                             end_of_string: (x6 == CODE_TERM)};
                                emit_now = 1'b1;
                                if (x6 == CODE_TERM) begin
                                    active = 1'b0;
                                    v      = '0;
                                    h      = '0;
                                    esc    = 1'b0;
                                end
                            end
                        end
                    end
                end
                if (emit_now) begin
                    if (cnt == 2'd0) begin
                        o_pair.first = res;
                    end else begin
                        o_pair.second = res;
                    end
                    cnt = cnt + 2'd1;
                end
            end

            n_store  = v[STORE_W-1:0];
            n_held   = h[STORE_CNT_W-1:0];
            n_esc    = esc;
            n_short  = sc;
            n_active = active;
            o_emit   = (cnt != 2'd0);
            o_pair.two = (cnt == 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store  <= '0;
            r_held   <= '0;
            r_esc    <= 1'b0;
            r_short  <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_store  <= n_store;
            r_held   <= n_held;
            r_esc    <= n_esc;
            r_short  <= n_short;
            r_active <= n_active;
        end
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= STORE_CNT_W'(STORE_W))
        else $error("bit buffer holds more leftover bits than it can");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_held == '0 && !r_esc))
        else $error("idle decoder keeps buffered bits or a pending escape");

    a_esc_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> !r_short)
        else $error("escape pending in 5-bit mode");

endmodule

@@ design/ptsd_queue.sv @@
`timescale 1ns / 1ps

module ptsd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ptsd_pkg::t_pair i_pair,
    input  logic            i_pop,
    output ptsd_pkg::t_pair o_pair,
    output logic            o_empty,
    output logic            o_full
);
    import ptsd_pkg::*;

    t_pair                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr, n_wr;
    logic [QUEUE_AW-1:0]  r_rd, n_rd;
    logic [QUEUE_AW:0]    r_count, n_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_pair  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = do_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ design/ptsd_back.sv @@
`timescale 1ns / 1ps

module ptsd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptsd_pkg::t_pair     i_q_pair,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output ptsd_pkg::t_out_item o_result
);
    import ptsd_pkg::*;

    t_pair r_pair;
    logic  r_valid, n_valid;
    logic  r_idx, n_idx;
    logic  take;
    logic  last_sub;
    logic  load;

    assign take     = r_valid && i_pop;
    assign last_sub = !r_pair.two || r_idx;
    // fill the output register from the queue when empty or on its last take
    assign load     = !i_q_empty && (!r_valid || (take && last_sub));
    assign o_q_pop  = load;
    assign o_empty  = !r_valid;
    assign o_result = r_idx ? r_pair.second : r_pair.first;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = 1'b0;
        end else if (take) begin
            if (last_sub) begin
                n_valid = 1'b0;
                n_idx   = 1'b0;
            end else begin
                n_idx = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pair <= i_q_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    a_second_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx |-> (r_valid && r_pair.two))
        else $error("second character selected from a single-character entry");

endmodule
